/* design/sortable_stack_engine_top_macros.svh */
`ifndef SORTABLE_STACK_ENGINE_TOP_MACROS_SVH
`define SORTABLE_STACK_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define SSE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define SSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/sse_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sse_pkg;

  // Default number of records the stack holds.
  localparam int unsigned STACK_DEPTH = 16;

  typedef enum logic [2:0] {
    FUNC_PUSH  = 3'd0,
    FUNC_POP   = 3'd1,
    FUNC_CLEAR = 3'd2,
    FUNC_PEEK  = 3'd3,
    FUNC_SORT  = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]         func;
    logic [63:0]        name_tag;
    logic [7:0]         kind;
    logic signed [31:0] item_value;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [63:0]        out_name_tag;
    logic [7:0]         out_kind;
    logic signed [31:0] out_value;
  } out_t;

  // One stored record.
  typedef struct packed {
    logic [63:0]        tag;
    logic [7:0]         kind;
    logic signed [31:0] value;
  } rec_t;

  localparam int unsigned REC_W = $bits(rec_t);

endpackage

`default_nettype wire

/* design/sse_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module sse_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* design/sortable_stack_engine_top.sv */
// Sortable stack engine. Each input beat carries one command (push, pop, clear,
// peek or sort) and every command returns exactly one output beat with a status
// and, for pop and peek, the top record. The records live in a single-port-pair
// RAM of StackDepth entries. Push and clear complete in the accepting cycle, so
// their registered result beat appears in the next cycle; pop and peek first
// pass through the S_POP state for the registered RAM read. Sort runs a stable
// insertion sort on the RAM under a small sequencer, with one signed comparator
// doing all compares. The single RAM read port delivers one record per cycle to
// the comparator. The input side is ready only while the sequencer is idle and
// the output register is empty or being emptied in the same cycle. A push onto
// a full stack is dropped with a full status, and pop or peek on an empty stack
// return an empty status.
`timescale 1ns / 1ps
`default_nettype none
`include "sortable_stack_engine_top_macros.svh"

module sortable_stack_engine_top #(
  parameter int unsigned StackDepth = sse_pkg::STACK_DEPTH
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire sse_pkg::in_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output sse_pkg::out_t     out_data_o
);

  localparam int unsigned AddrW = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned CntW  = $clog2(StackDepth + 1);

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_POP   = 6'b000010,
    S_LDCUR = 6'b000100,
    S_SCMP  = 6'b001000,
    S_SWR   = 6'b010000,
    S_SDONE = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [CntW-1:0] top_q, top_d;
  logic [CntW-1:0] i_q, i_d;     // record being inserted during sort
  logic [CntW-1:0] j_q, j_d;     // hole position during sort
  logic            pop_q, pop_d; // the pending read is a pop, not a peek

  sse_pkg::rec_t cur_q, cur_d;
  sse_pkg::out_t out_data_q, out_data_d;
  logic          out_valid_q, out_valid_d;

  // RAM port signals.
  logic                      ram_we;
  logic [AddrW-1:0]          ram_waddr;
  sse_pkg::rec_t             ram_wdata;
  logic                      ram_re;
  logic [AddrW-1:0]          ram_raddr;
  logic [sse_pkg::REC_W-1:0] ram_rdata;
  sse_pkg::rec_t             rd_rec;

  logic            out_free;
  logic            stack_full;
  logic            stack_empty;
  logic [CntW-1:0] top_m1;
  logic [CntW-1:0] top_p1;
  logic [CntW-1:0] i_p1;
  logic [CntW-1:0] i_m1;
  logic [CntW-1:0] j_m1;
  logic [CntW-1:0] j_m2;
  logic            shift_up;
  sse_pkg::func_e  func;
  sse_pkg::rec_t   push_rec;

  assign rd_rec      = sse_pkg::rec_t'(ram_rdata);
  assign out_free    = !out_valid_q || out_ready_i;
  assign stack_full  = (top_q == CntW'(StackDepth));
  assign stack_empty = (top_q == '0);
  assign top_m1      = top_q - 1'b1;
  assign top_p1      = top_q + 1'b1;
  assign i_p1        = i_q + 1'b1;
  assign i_m1        = i_q - 1'b1;
  assign j_m1        = j_q - 1'b1;
  assign j_m2        = j_q - 2'd2;
  assign func        = sse_pkg::func_e'(in_data_i.func);

  // The one comparator: the record below the hole moves up when its value is
  // strictly smaller, which keeps equal values in their original order.
  assign shift_up = (rd_rec.value < cur_q.value);

  assign push_rec.tag   = in_data_i.name_tag;
  assign push_rec.kind  = in_data_i.kind;
  assign push_rec.value = in_data_i.item_value;

  assign in_ready_o  = (state_q == S_IDLE) && out_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    state_d     = state_q;
    top_d       = top_q;
    i_d         = i_q;
    j_d         = j_q;
    pop_d       = pop_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = top_q[AddrW-1:0];
    ram_wdata   = push_rec;
    ram_re      = 1'b0;
    ram_raddr   = top_m1[AddrW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          out_data_d        = '0;
          out_data_d.status = sse_pkg::ST_OK;
          unique case (func) inside
            sse_pkg::FUNC_PUSH: begin
              out_valid_d = 1'b1;
              if (stack_full) begin
                out_data_d.status = sse_pkg::ST_FULL;
              end else begin
                ram_we = 1'b1;
                top_d  = top_p1;
              end
            end
            sse_pkg::FUNC_POP, sse_pkg::FUNC_PEEK: begin
              if (stack_empty) begin
                out_valid_d       = 1'b1;
                out_data_d.status = sse_pkg::ST_EMPTY;
              end else begin
                ram_re  = 1'b1;
                pop_d   = (func == sse_pkg::FUNC_POP);
                state_d = S_POP;
              end
            end
            sse_pkg::FUNC_CLEAR: begin
              out_valid_d = 1'b1;
              top_d       = '0;
            end
            sse_pkg::FUNC_SORT: begin
              if (top_q < CntW'(2)) begin
                out_valid_d = 1'b1;
              end else begin
                i_d       = CntW'(1);
                ram_re    = 1'b1;
                ram_raddr = AddrW'(1);
                state_d   = S_LDCUR;
              end
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        if (out_free) begin
          out_valid_d             = 1'b1;
          out_data_d.status       = sse_pkg::ST_OK;
          out_data_d.out_name_tag = rd_rec.tag;
          out_data_d.out_kind     = rd_rec.kind;
          out_data_d.out_value    = rd_rec.value;
          if (pop_q) begin
            top_d = top_m1;
          end
          state_d = S_IDLE;
        end
      end
      S_LDCUR: begin
        cur_d     = rd_rec;
        j_d       = i_q;
        ram_re    = 1'b1;
        ram_raddr = i_m1[AddrW-1:0];
        state_d   = S_SCMP;
      end
      S_SCMP: begin
        if (shift_up) begin
          ram_we    = 1'b1;
          ram_waddr = j_q[AddrW-1:0];
          ram_wdata = rd_rec;
          j_d       = j_m1;
          if (j_q == CntW'(1)) begin
            state_d = S_SWR;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = j_m2[AddrW-1:0];
          end
        end else begin
          state_d = S_SWR;
        end
      end
      S_SWR: begin
        ram_we    = 1'b1;
        ram_waddr = j_q[AddrW-1:0];
        ram_wdata = cur_q;
        i_d       = i_p1;
        if (i_p1 == top_q) begin
          state_d = S_SDONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = i_p1[AddrW-1:0];
          state_d   = S_LDCUR;
        end
      end
      S_SDONE: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_data_d        = '0;
          out_data_d.status = sse_pkg::ST_OK;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      top_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      pop_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      i_q         <= i_d;
      j_q         <= j_d;
      pop_q       <= pop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    out_data_q <= out_data_d;
  end

  sse_ram #(
    .Width(sse_pkg::REC_W),
    .Depth(StackDepth),
    .AddrW(AddrW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // The fill count never passes the capacity.
  `SSE_ASSERT_NOW(a_top_bound, 1'b1, top_q <= CntW'(StackDepth), "stack count above depth")

  // A push onto a full stack leaves the count alone and reports full.
  `SSE_ASSERT_NEXT(a_full_drop, in_valid_i && in_ready_o && stack_full && func == sse_pkg::FUNC_PUSH, top_q == $past(top_q) && out_data_q.status == sse_pkg::ST_FULL, "full push not dropped")

  // The sort walk never moves the fill count.
  `SSE_ASSERT_NEXT(a_sort_count, state_q == S_LDCUR || state_q == S_SCMP || state_q == S_SWR, $stable(top_q), "count changed during sort")

  // While comparing, the hole sits above the bottom and at or below the record.
  `SSE_ASSERT_NOW(a_hole_range, state_q == S_SCMP, j_q != '0 && j_q <= i_q && i_q < top_q, "sort hole out of range")

endmodule

`default_nettype wire
